[src/cabs_pkg.sv]
// ----------------------------------------------------------------------------
// cabs_pkg
// Shared types and constants of the clock-hand block scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cabs_pkg;

    localparam int unsigned NODE_W     = 4;   // node id fields
    localparam int unsigned HAND_W     = 5;   // hand, miss run, ring size
    localparam int unsigned CREDIT_W   = 16;
    localparam int unsigned BASE_W     = 8;
    localparam int unsigned BLKNUM_W   = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_AVAIL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PROBE,
        S_BUMP,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic check;
        logic probe;
        logic bump;
        logic deliver;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic bad;
        logic hit;
        logic bump;
        logic guard_end;
        logic bump_last;
        logic exhaust;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[src/cabs_ram.sv]
// ----------------------------------------------------------------------------
// cabs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cabs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[src/cabs_ctrl.sv]
// ----------------------------------------------------------------------------
// cabs_ctrl
// Sequencer of the scheduler: check, probe walk, credit bump sweep, delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module cabs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire cabs_pkg::t_sts  i_sts,
    output cabs_pkg::t_cmd       o_cmd
);

    cabs_pkg::t_state r_state;
    cabs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cabs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            cabs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = cabs_pkg::S_CHECK;
                end
            end
            cabs_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.bad ? cabs_pkg::S_DONE : cabs_pkg::S_PROBE;
            end
            cabs_pkg::S_PROBE: begin
                o_cmd.probe = 1'b1;
                priority if (i_sts.hit) begin
                    n_state = cabs_pkg::S_DONE;
                end else if (i_sts.bump) begin
                    n_state = cabs_pkg::S_BUMP;
                end else if (i_sts.guard_end) begin
                    n_state = cabs_pkg::S_DONE;
                end else begin
                    n_state = cabs_pkg::S_PROBE;
                end
            end
            cabs_pkg::S_BUMP: begin
                o_cmd.bump = 1'b1;
                if (i_sts.bump_last) begin
                    n_state = i_sts.exhaust ? cabs_pkg::S_DONE : cabs_pkg::S_PROBE;
                end
            end
            cabs_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.deliver = 1'b1;
                    n_state       = cabs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cabs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/cabs_dp.sv]
// ----------------------------------------------------------------------------
// cabs_dp
// Datapath: config registers, credit RAM with valid bits, hand, miss run,
// block counter, probe guard, bump sweep and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cabs_dp #(
    parameter int NODES = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cabs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cabs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                              i_new_job,
    input  wire logic [cabs_pkg::NODE_W-1:0]       i_first_copy_node,
    input  wire logic [cabs_pkg::NODE_W-1:0]       i_second_copy_node,
    input  wire cabs_pkg::t_cmd                    i_cmd,
    output cabs_pkg::t_sts                         o_sts,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [cabs_pkg::NODE_W-1:0]            o_assigned_worker,
    output logic [cabs_pkg::BLKNUM_W-1:0]          o_block_number,
    output logic                                   o_unassignable
);

    localparam int HW    = cabs_pkg::HAND_W;
    localparam int NW    = cabs_pkg::NODE_W;
    localparam int CW    = cabs_pkg::CREDIT_W;
    localparam int BW    = cabs_pkg::BASE_W;
    localparam int KW    = cabs_pkg::BLKNUM_W;
    localparam int AW    = $clog2(NODES);
    localparam int LIMIT = 4 * NODES + 4;
    localparam int GW    = $clog2(LIMIT);
    localparam logic [GW-1:0] GUARD_LAST = GW'(LIMIT - 1);

    // config
    logic [HW-1:0]  r_node_count;
    logic [BW-1:0]  r_base;

    // scheduler state
    logic [NODES-1:0] r_vld;
    logic [CW-1:0]    r_fill;
    logic [HW-1:0]    r_hand;
    logic [HW-1:0]    r_miss;
    logic [KW-1:0]    r_bc;
    logic [GW-1:0]    r_guard;
    logic [HW-1:0]    r_sw;
    logic             r_exhaust;

    // item and result
    logic [NW-1:0]  r_a;
    logic [NW-1:0]  r_b;
    logic [KW-1:0]  r_res_bn;
    logic [NW-1:0]  r_res_worker;
    logic           r_res_unas;
    logic           r_out_vld;
    logic [NW-1:0]  r_out_worker;
    logic [KW-1:0]  r_out_bn;
    logic           r_out_unas;

    // read side of the credit RAM
    logic           r_rd_vld;
    logic           r_fwd;
    logic [CW-1:0]  r_fwd_data;
    logic [CW-1:0]  ram_q;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [CW-1:0]  ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;

    logic [HW-1:0]  ring;
    logic [HW-1:0]  w;
    logic [HW-1:0]  w_inc;
    logic [HW-1:0]  nxt;
    logic [CW-1:0]  q_eff;
    logic [HW-1:0]  miss_inc;
    logic [CW:0]    sum;
    logic [CW-1:0]  sat;
    logic           is_zero;
    logic           is_hit;
    logic           bump_now;
    logic           guard_end;
    logic           bad;
    logic           bump_last;
    logic           out_free;

    cabs_ram #(
        .WIDTH (CW),
        .DEPTH (NODES)
    ) u_credit (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        if (r_node_count == '0) begin
            ring = HW'(1);
        end else if (int'(r_node_count) > NODES) begin
            ring = HW'(NODES);
        end else begin
            ring = r_node_count;
        end
    end

    assign w         = (r_hand >= ring) ? '0 : r_hand;
    assign w_inc     = w + HW'(1);
    assign nxt       = (w_inc >= ring) ? '0 : w_inc;
    // entries not written since the last fill read as the fill value
    assign q_eff     = r_fwd ? r_fwd_data : (r_rd_vld ? ram_q : r_fill);
    assign miss_inc  = (&r_miss) ? r_miss : r_miss + HW'(1);
    assign sum       = {1'b0, q_eff} + (CW + 1)'(r_base);
    assign sat       = sum[CW] ? '1 : sum[CW-1:0];
    assign is_zero   = (q_eff == '0);
    assign is_hit    = !is_zero && (w == HW'(r_a) || w == HW'(r_b));
    assign bump_now  = !is_zero && !is_hit && (miss_inc >= ring);
    assign guard_end = (r_guard == GUARD_LAST);
    assign bad       = (HW'(r_a) >= ring && HW'(r_b) >= ring) || (r_base == '0);
    assign bump_last = (r_sw == ring);
    assign out_free  = !r_out_vld || i_out_ready;

    always_comb begin
        o_sts           = '0;
        o_sts.bad       = bad;
        o_sts.hit       = is_hit;
        o_sts.bump      = bump_now;
        o_sts.guard_end = guard_end;
        o_sts.bump_last = bump_last;
        o_sts.exhaust   = r_exhaust;
        o_sts.out_free  = out_free;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (i_cmd.check && !bad) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(w);
        end
        if (i_cmd.probe) begin
            if (is_zero) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(w);
                ram_wdata = CW'(r_base);
            end else if (is_hit) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(w);
                ram_wdata = q_eff - CW'(1);
            end
            // next worker is read while this one is decided
            if (!is_hit && !bump_now && !guard_end) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(nxt);
            end
        end
        if (i_cmd.bump) begin
            // read entry r_sw, write back entry r_sw-1 in the next cycle
            if (r_sw < ring) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(r_sw);
            end
            if (r_sw != '0) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_sw - HW'(1));
                ram_wdata = sat;
            end
            if (bump_last && !r_exhaust) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= HW'(1);
            r_base       <= BW'(1);
            r_vld        <= '0;
            r_fill       <= CW'(1);
            r_hand       <= '0;
            r_miss       <= '0;
            r_bc         <= '0;
            r_guard      <= '0;
            r_sw         <= '0;
            r_exhaust    <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_fwd        <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cabs_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_wdata[HW-1:0];
                    cabs_pkg::CFG_BASE_AVAIL: r_base       <= i_cfg_wdata[BW-1:0];
                endcase
            end

            if (i_cmd.accept && i_new_job) begin
                r_vld  <= '0;
                r_fill <= CW'(r_base);
                r_hand <= '0;
                r_bc   <= '0;
            end else if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end

            if (ram_re) begin
                r_rd_vld <= r_vld[ram_raddr];
                r_fwd    <= ram_we && (ram_waddr == ram_raddr);
            end

            if (i_cmd.check) begin
                r_guard <= '0;
            end

            if (i_cmd.probe) begin
                r_hand  <= w_inc;
                r_guard <= r_guard + GW'(1);
                if (is_zero) begin
                    r_miss <= miss_inc;
                end else if (is_hit) begin
                    r_miss <= '0;
                    r_bc   <= r_bc + KW'(1);
                end else begin
                    r_miss <= bump_now ? '0 : miss_inc;
                end
                if (bump_now) begin
                    r_sw      <= '0;
                    r_exhaust <= guard_end;
                end
            end

            if (i_cmd.bump) begin
                r_sw <= r_sw + HW'(1);
            end

            if (i_cmd.deliver) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_fwd_data <= ram_wdata;
        end
        if (i_cmd.accept) begin
            r_a      <= i_first_copy_node;
            r_b      <= i_second_copy_node;
            r_res_bn <= i_new_job ? '0 : r_bc;
        end
        if ((i_cmd.check && bad)
            || (i_cmd.probe && !is_hit && !bump_now && guard_end)
            || (i_cmd.bump && bump_last && r_exhaust)) begin
            r_res_worker <= '0;
            r_res_unas   <= 1'b1;
        end else if (i_cmd.probe && is_hit) begin
            r_res_worker <= w[NW-1:0];
            r_res_unas   <= 1'b0;
        end
        if (i_cmd.deliver) begin
            r_out_worker <= r_res_worker;
            r_out_bn     <= r_res_bn;
            r_out_unas   <= r_res_unas;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_assigned_worker = r_out_worker;
    assign o_block_number    = r_out_bn;
    assign o_unassignable    = r_out_unas;

endmodule

`default_nettype wire

[src/clock_availability_block_scheduler.sv]
// ----------------------------------------------------------------------------
// clock_availability_block_scheduler
// Places each data block on a worker of a ring with a credit-based clock hand.
// Input channel (i_in_valid/o_in_ready) takes one word: new-job flag and the
// two replica node ids. Output channel (o_out_valid/i_out_ready) returns one
// word per input: assigned worker, block number and the unassignable flag.
// Config is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_wdata), idle only.
// Timing: one probe of the credit RAM per cycle in the probe walk. After
// acceptance the block is checked, then probed (1 to 4*NODES+4 probes);
// a miss run that reaches the ring size starts a credit bump sweep over the
// n active workers, one RAM word per cycle. A block failing the check skips
// the walk. One block is in work at a time, the next taken after delivery.
// Stall: the output register holds its word until taken; a new word may be
// accepted meanwhile, its result waits until the register is free.
// Reset: credits read as 1 via per-worker valid bits (no clearing pass),
// hand, miss run and block number are zero, ring size and base credit are 1.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_availability_block_scheduler #(
    parameter int NODES = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cabs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cabs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_new_job,
    input  wire logic [cabs_pkg::NODE_W-1:0]       i_first_copy_node,
    input  wire logic [cabs_pkg::NODE_W-1:0]       i_second_copy_node,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [cabs_pkg::NODE_W-1:0]            o_assigned_worker,
    output logic [cabs_pkg::BLKNUM_W-1:0]          o_block_number,
    output logic                                   o_unassignable
);

    cabs_pkg::t_cmd cmd;
    cabs_pkg::t_sts sts;

    cabs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cabs_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_new_job          (i_new_job),
        .i_first_copy_node  (i_first_copy_node),
        .i_second_copy_node (i_second_copy_node),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_assigned_worker  (o_assigned_worker),
        .o_block_number     (o_block_number),
        .o_unassignable     (o_unassignable)
    );

endmodule

`default_nettype wire
